// File: hw/rtl/gsd_pkg.sv
// Shared constants, types and helper functions for the swipe gesture decoder.
// No dependencies; imported by gsd_divider and swipe_gesture_decoder.

package gsd_pkg;

    localparam int MAX_BATCH   = 32;
    localparam int MIN_BATCH   = 4;
    localparam int NEAR_NEEDED = 10;
    localparam int FAR_NEEDED  = 2;
    localparam int COUNT_MAX   = 63;
    localparam int RATIO_SCALE = 100;

    localparam int CHAN_W  = 8;
    localparam int DEN_W   = CHAN_W + 1;           // a + b
    localparam int QUO_W   = 7;                    // |ratio| <= 100
    localparam int MAG_W   = DEN_W + QUO_W - 1;    // |a - b| * 100
    localparam int RATIO_W = QUO_W + 1;            // signed ratio
    localparam int DELTA_W = RATIO_W + 1;          // difference of two ratios
    localparam int ACC_W   = 16;
    localparam int CNT_W   = 6;
    localparam int SENS_W  = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_SWIPE_SENS  = 2'd1;
    localparam logic [1:0] REG_STILL_SENS  = 2'd2;

    // Proximity states
    localparam logic [1:0] PROX_NONE = 2'd0;
    localparam logic [1:0] PROX_NEAR = 2'd1;
    localparam logic [1:0] PROX_FAR  = 2'd2;

    // Direction codes
    localparam logic [2:0] GEST_NONE  = 3'd0;
    localparam logic [2:0] GEST_LEFT  = 3'd1;
    localparam logic [2:0] GEST_RIGHT = 3'd2;
    localparam logic [2:0] GEST_UP    = 3'd3;
    localparam logic [2:0] GEST_DOWN  = 3'd4;
    localparam logic [2:0] GEST_NEAR  = 3'd5;
    localparam logic [2:0] GEST_FAR   = 3'd6;

    // Votes
    localparam logic signed [1:0] VOTE_ZERO = 2'sb00;
    localparam logic signed [1:0] VOTE_POS  = 2'sb01;
    localparam logic signed [1:0] VOTE_NEG  = 2'sb11;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        logic  start;
        chan_t num_a;
        chan_t num_b;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [RATIO_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic signed [1:0] make_vote(
        input logic signed [ACC_W-1:0] acc,
        input logic [SENS_W-1:0]       sens
    );
        logic signed [ACC_W:0] acc_x;
        logic signed [ACC_W:0] sens_x;
        acc_x  = {acc[ACC_W-1], acc};
        sens_x = {{(ACC_W + 1 - SENS_W){1'b0}}, sens};
        if (acc_x >= sens_x) begin
            return VOTE_POS;
        end else if (acc_x <= -sens_x) begin
            return VOTE_NEG;
        end
        return VOTE_ZERO;
    endfunction

    function automatic logic [ACC_W:0] acc_mag(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] acc_x;
        acc_x = {acc[ACC_W-1], acc};
        return acc_x[ACC_W] ? (ACC_W+1)'(0) - acc_x : acc_x;
    endfunction

    function automatic logic [2:0] decode_dir(
        input logic [1:0]              prox,
        input logic signed [1:0]       v_vote,
        input logic signed [1:0]       h_vote,
        input logic signed [ACC_W-1:0] v_acc,
        input logic signed [ACC_W-1:0] h_acc,
        input logic [2:0]              motion
    );
        logic [2:0] v_dir;
        logic [2:0] h_dir;
        v_dir = v_vote[1] ? GEST_RIGHT : GEST_LEFT;
        h_dir = h_vote[1] ? GEST_UP : GEST_DOWN;
        if (prox == PROX_NEAR) begin
            return GEST_NEAR;
        end else if (prox == PROX_FAR) begin
            return GEST_FAR;
        end else if (v_vote != VOTE_ZERO && h_vote == VOTE_ZERO) begin
            return v_dir;
        end else if (v_vote == VOTE_ZERO && h_vote != VOTE_ZERO) begin
            return h_dir;
        end else if (v_vote != VOTE_ZERO && h_vote != VOTE_ZERO) begin
            return (acc_mag(v_acc) > acc_mag(h_acc)) ? v_dir : h_dir;
        end
        return motion;
    endfunction

endpackage

// File: hw/rtl/gsd_divider.sv
// Ratio unit: truncating 100*(a-b)/(a+b), one quotient bit per cycle.
// Depends on gsd_pkg for widths and the request/response structs.

module gsd_divider
    import gsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [CHAN_W-1:0] diff;
    logic [MAG_W-1:0]  mag;
    logic [DEN_W-1:0]  den;
    logic              rem_ge;
    logic [MAG_W-1:0]  rem_sub;

    logic [MAG_W-1:0] rem_reg,    rem_next;
    logic [MAG_W-1:0] den_sh_reg, den_sh_next;
    logic [QUO_W-1:0] quo_reg,    quo_next;
    logic [2:0]       step_reg,   step_next;
    logic             neg_reg,    neg_next;
    logic             zero_reg,   zero_next;
    logic             busy_reg,   busy_next;
    logic             done_reg,   done_next;

    logic signed [RATIO_W-1:0] quo_pos;

    always_comb begin
        diff    = (req.num_a >= req.num_b) ? req.num_a - req.num_b : req.num_b - req.num_a;
        mag     = MAG_W'(diff) * MAG_W'(RATIO_SCALE);
        den     = {1'b0, req.num_a} + {1'b0, req.num_b};
        rem_ge  = rem_reg >= den_sh_reg;
        rem_sub = rem_reg - den_sh_reg;
    end

    always_comb begin
        rem_next    = rem_reg;
        den_sh_next = den_sh_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start) begin
            rem_next    = mag;
            den_sh_next = {den, {(QUO_W-1){1'b0}}};
            quo_next    = '0;
            step_next   = 3'(QUO_W - 1);
            neg_next    = req.num_a < req.num_b;
            zero_next   = den == '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // restoring step: subtract the shifted divisor when it fits
            if (rem_ge) begin
                rem_next = rem_sub;
            end
            quo_next    = {quo_reg[QUO_W-2:0], rem_ge};
            den_sh_next = den_sh_reg >> 1;
            if (step_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        den_sh_reg <= den_sh_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quo_pos      = {1'b0, quo_reg};
    assign rsp.done     = done_reg;
    assign rsp.quotient = zero_reg ? '0 : (neg_reg ? -quo_pos : quo_pos);

endmodule

// File: hw/rtl/swipe_gesture_decoder.sv
// Swipe gesture decoder top level: sample capture, batch sequencer, accumulators.
// Depends on gsd_pkg and gsd_divider (shared ratio unit).
//
//  Channel   Ports                                   Payload (low bit first)
//  --------  --------------------------------------  ------------------------------------
//  input     s_tvalid s_tready s_tdata s_tuser s_tlast  up, down, left, right; tuser: op;
//                                                    tlast: last sample of a FIFO batch
//  result    m_tvalid m_tready m_tdata                direction (3 bits), zero padded
//  config    cfg_valid cfg_ready cfg_index cfg_data  0 threshold, 1 swipe, 2 still sens.
//
//  A batch-closing sample whose batch is used runs four ratios one after another
//  through the single ratio unit, each with a start state, the quotient bits and a
//  result, then an accumulate state and a vote state. A gesture-end transfer waits
//  in the end state while the result register is still held by a stalled receiver.
//  s_tready is low while an item is in work. Reset (aresetn low, synchronous) loads
//  the register defaults and clears the gesture state except the first and latest
//  samples and the ratio deltas; no clearing pass follows. Config writes are always taken.

module swipe_gesture_decoder
    import gsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // up[7:0], down[15:8], left[23:16], right[31:24]
    input  logic [0:0]  s_tuser,    // operation[0]: 0 sample, 1 gesture end
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // direction[2:0], zeros above
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV_START = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
    localparam logic [2:0] ST_ACCUM     = 3'd3;
    localparam logic [2:0] ST_VOTE      = 3'd4;
    localparam logic [2:0] ST_END       = 3'd5;

    // Config registers
    logic [SENS_W-1:0] thr_reg,         thr_next;
    logic [SENS_W-1:0] swipe_sens_reg,  swipe_sens_next;
    logic [SENS_W-1:0] still_sens_reg,  still_sens_next;

    // Sequencer
    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    // Gesture state
    logic [31:0]              first_reg,    first_next;
    logic [31:0]              latest_reg,   latest_next;
    logic                     found_reg,    found_next;
    logic [CNT_W-1:0]         count_reg,    count_next;
    logic signed [DELTA_W-1:0] ud_reg,      ud_next;
    logic signed [DELTA_W-1:0] lr_reg,      lr_next;
    logic signed [ACC_W-1:0]  vacc_reg,     vacc_next;
    logic signed [ACC_W-1:0]  hacc_reg,     hacc_next;
    logic signed [1:0]        vvote_reg,    vvote_next;
    logic signed [1:0]        hvote_reg,    hvote_next;
    logic [7:0]               near_reg,     near_next;
    logic [7:0]               far_reg,      far_next;
    logic [1:0]               prox_reg,     prox_next;
    logic [2:0]               motion_reg,   motion_next;

    // Result register
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_dir_reg,   m_dir_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              s_fire;
    logic              cfg_fire;
    logic              qualify;
    logic [CNT_W:0]    total;
    logic              batch_go;
    logic [31:0]       div_src;
    logic              end_go;

    logic signed [ACC_W:0]     vsum;
    logic signed [ACC_W:0]     hsum;
    logic signed [1:0]         vv;
    logic signed [1:0]         hv;
    logic [DELTA_W-1:0]        ud_mag;
    logic [DELTA_W-1:0]        lr_mag;
    logic                      small_move;
    logic                      both_zero;
    logic [7:0]                near_inc;
    logic [7:0]                far_inc;

    gsd_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, m_dir_reg};

    // A sample qualifies only when every channel is strictly above threshold
    assign qualify = (s_tdata[7:0] > thr_reg) && (s_tdata[15:8] > thr_reg) &&
                     (s_tdata[23:16] > thr_reg) && (s_tdata[31:24] > thr_reg);
    assign total    = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign batch_go = (total > (CNT_W+1)'(MIN_BATCH)) &&
                      (total <= (CNT_W+1)'(MAX_BATCH)) && (found_reg || qualify);
    assign end_go   = !m_valid_reg || m_tready;

    // Ratio operands: latest then first for up/down, then the same for left/right
    assign div_src       = phase_reg[0] ? first_reg : latest_reg;
    assign div_req.start = state_reg == ST_DIV_START;
    assign div_req.num_a = phase_reg[1] ? div_src[23:16] : div_src[7:0];
    assign div_req.num_b = phase_reg[1] ? div_src[31:24] : div_src[15:8];

    // Accumulate and vote datapath
    always_comb begin
        vsum       = {vacc_reg[ACC_W-1], vacc_reg} + (ACC_W+1)'(ud_reg);
        hsum       = {hacc_reg[ACC_W-1], hacc_reg} + (ACC_W+1)'(lr_reg);
        vv         = make_vote(vacc_reg, swipe_sens_reg);
        hv         = make_vote(hacc_reg, swipe_sens_reg);
        ud_mag     = ud_reg[DELTA_W-1] ? DELTA_W'(-ud_reg) : DELTA_W'(ud_reg);
        lr_mag     = lr_reg[DELTA_W-1] ? DELTA_W'(-lr_reg) : DELTA_W'(lr_reg);
        small_move = (ud_mag < DELTA_W'(still_sens_reg)) && (lr_mag < DELTA_W'(still_sens_reg));
        both_zero  = (ud_reg == '0) && (lr_reg == '0);
        near_inc   = (near_reg == 8'hFF) ? near_reg : near_reg + 8'd1;
        far_inc    = (far_reg == 8'hFF) ? far_reg : far_reg + 8'd1;
    end

    always_comb begin
        thr_next        = thr_reg;
        swipe_sens_next = swipe_sens_reg;
        still_sens_next = still_sens_reg;
        state_next      = state_reg;
        phase_next      = phase_reg;
        first_next      = first_reg;
        latest_next     = latest_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        ud_next         = ud_reg;
        lr_next         = lr_reg;
        vacc_next       = vacc_reg;
        hacc_next       = hacc_reg;
        vvote_next      = vvote_reg;
        hvote_next      = hvote_reg;
        near_next       = near_reg;
        far_next        = far_reg;
        prox_next       = prox_reg;
        motion_next     = motion_reg;
        m_valid_next    = m_valid_reg;
        m_dir_next      = m_dir_reg;

        if (cfg_fire) begin
            unique case (cfg_index)
                REG_THRESHOLD:  thr_next        = cfg_data;
                REG_SWIPE_SENS: swipe_sens_next = cfg_data;
                REG_STILL_SENS: still_sens_next = cfg_data;
                default: ;
            endcase
        end

        // Drop the result once it has been transferred
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0]) begin
                        state_next = ST_END;
                    end else begin
                        if (qualify) begin
                            if (!found_reg) begin
                                first_next = s_tdata;
                                found_next = 1'b1;
                            end
                            latest_next = s_tdata;
                        end
                        if (s_tlast) begin
                            count_next = '0;
                            found_next = 1'b0;
                            if (batch_go) begin
                                phase_next = 2'd0;
                                state_next = ST_DIV_START;
                            end
                        end else if (count_reg != CNT_W'(COUNT_MAX)) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    // Delta is latest ratio minus first ratio
                    if (phase_reg[1]) begin
                        lr_next = phase_reg[0] ? lr_reg - DELTA_W'(div_rsp.quotient)
                                               : DELTA_W'(div_rsp.quotient);
                    end else begin
                        ud_next = phase_reg[0] ? ud_reg - DELTA_W'(div_rsp.quotient)
                                               : DELTA_W'(div_rsp.quotient);
                    end
                    if (phase_reg == 2'd3) begin
                        state_next = ST_ACCUM;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_ACCUM: begin
                // Saturate to the 16-bit signed range
                if (vsum[ACC_W] != vsum[ACC_W-1]) begin
                    vacc_next = vsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    vacc_next = vsum[ACC_W-1:0];
                end
                if (hsum[ACC_W] != hsum[ACC_W-1]) begin
                    hacc_next = hsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    hacc_next = hsum[ACC_W-1:0];
                end
                state_next = ST_VOTE;
            end
            ST_VOTE: begin
                vvote_next = vv;
                hvote_next = hv;
                if (vv == VOTE_ZERO && hv == VOTE_ZERO) begin
                    if (small_move) begin
                        if (both_zero) begin
                            near_next = near_inc;
                        end else begin
                            far_next = far_inc;
                        end
                        if (near_next >= 8'(NEAR_NEEDED) && far_next >= 8'(FAR_NEEDED)) begin
                            if (both_zero) begin
                                prox_next = PROX_NEAR;
                            end else if (ud_reg != '0 && lr_reg != '0) begin
                                prox_next = PROX_FAR;
                            end
                            // Votes are zero here, so only proximity can set the code
                            if (prox_next == PROX_NEAR) begin
                                motion_next = GEST_NEAR;
                            end else if (prox_next == PROX_FAR) begin
                                motion_next = GEST_FAR;
                            end
                        end
                    end
                end else if (small_move) begin
                    if (both_zero) begin
                        near_next = near_inc;
                    end
                    if (near_next >= 8'(NEAR_NEEDED)) begin
                        vvote_next = VOTE_ZERO;
                        hvote_next = VOTE_ZERO;
                        vacc_next  = '0;
                        hacc_next  = '0;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_END: begin
                // Hold until the result register is free, then emit and clear
                if (end_go) begin
                    m_valid_next = 1'b1;
                    m_dir_next   = decode_dir(prox_reg, vvote_reg, hvote_reg,
                                              vacc_reg, hacc_reg, motion_reg);
                    first_next   = '0;
                    latest_next  = '0;
                    found_next   = 1'b0;
                    count_next   = '0;
                    vacc_next    = '0;
                    hacc_next    = '0;
                    vvote_next   = VOTE_ZERO;
                    hvote_next   = VOTE_ZERO;
                    near_next    = '0;
                    far_next     = '0;
                    prox_next    = PROX_NONE;
                    motion_next  = GEST_NONE;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        first_reg  <= first_next;
        latest_reg <= latest_next;
        ud_reg     <= ud_next;
        lr_reg     <= lr_next;
        m_dir_reg  <= m_dir_next;
        phase_reg  <= phase_next;
        if (!aresetn) begin
            thr_reg        <= 8'd10;
            swipe_sens_reg <= 8'd50;
            still_sens_reg <= 8'd20;
            state_reg      <= ST_IDLE;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            vacc_reg       <= '0;
            hacc_reg       <= '0;
            vvote_reg      <= VOTE_ZERO;
            hvote_reg      <= VOTE_ZERO;
            near_reg       <= '0;
            far_reg        <= '0;
            prox_reg       <= PROX_NONE;
            motion_reg     <= GEST_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            thr_reg        <= thr_next;
            swipe_sens_reg <= swipe_sens_next;
            still_sens_reg <= still_sens_next;
            state_reg      <= state_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
            vacc_reg       <= vacc_next;
            hacc_reg       <= hacc_next;
            vvote_reg      <= vvote_next;
            hvote_reg      <= hvote_next;
            near_reg       <= near_next;
            far_reg        <= far_next;
            prox_reg       <= prox_next;
            motion_reg     <= motion_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // The ratio unit reports only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("ratio unit finished outside a wait state");

    // A new result appears only from the gesture-end state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_END)
        else $error("result raised without a gesture end");

    // After a gesture end is emitted, the near/far counts, vertical accumulator and proximity are cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_END && end_go) |=>
            (near_reg == '0 && far_reg == '0 && vacc_reg == '0 && prox_reg == PROX_NONE))
        else $error("gesture state not cleared after gesture end");

    // Votes stay within -1, 0, +1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vvote_reg != 2'sb10) && (hvote_reg != 2'sb10))
        else $error("vote out of range");

endmodule
